// ===== sv/ipm_pkg.sv =====
`timescale 1ns / 1ps

package ipm_pkg;

  localparam int NODE_COUNT   = 4096;
  localparam int ADDRESS_BITS = 32;

  localparam int IDX_W   = $clog2(NODE_COUNT);
  localparam int CNT_W   = $clog2(NODE_COUNT + 1);
  localparam int LVL_W   = $clog2(ADDRESS_BITS + 1);
  localparam int BIT_W   = $clog2(ADDRESS_BITS);
  localparam int ACT_W   = 2;
  localparam int PLEN_W  = 6;

  localparam logic [ACT_W-1:0] ACT_INSERT = 2'd0;
  localparam logic [ACT_W-1:0] ACT_MATCH  = 2'd1;
  localparam logic [ACT_W-1:0] ACT_CLEAR  = 2'd2;

  typedef logic [IDX_W-1:0] idx_t;

  typedef struct packed {
    idx_t [1:0] child;
    logic       terminal;
  } node_t;

  typedef struct packed {
    logic [ACT_W-1:0]        action;
    logic [ADDRESS_BITS-1:0] address;
    logic [PLEN_W-1:0]       prefix_length;
  } ipm_in_t;

  typedef struct packed {
    logic matched;
    logic status;
  } ipm_out_t;

  typedef struct packed {
    logic init_root;
    logic load;
    logic step;
  } ipm_cmd_t;

  typedef struct packed {
    logic finish;
  } ipm_sts_t;

endpackage

// ===== sv/ipm_ctrl.sv =====
`timescale 1ns / 1ps

module ipm_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  logic [1:0]             action,
  input  ipm_pkg::ipm_sts_t      sts,
  output ipm_pkg::ipm_cmd_t      cmd,
  output logic                   busy,
  output logic                   out_strobe
);
  import ipm_pkg::*;

  localparam logic [1:0] ST_INIT = 2'd0;
  localparam logic [1:0] ST_IDLE = 2'd1;
  localparam logic [1:0] ST_WALK = 2'd2;

  logic [1:0] state_r;
  logic [1:0] state_nxt;
  logic       strobe_r;
  logic       strobe_nxt;
  logic       accept;
  logic       walk_req;

  assign accept   = start && (state_r == ST_IDLE);
  assign walk_req = (action == ACT_INSERT) || (action == ACT_MATCH);
  assign busy       = (state_r != ST_IDLE);
  assign out_strobe = strobe_r;

  always_comb begin
    state_nxt     = state_r;
    strobe_nxt    = 1'b0;
    cmd.init_root = 1'b0;
    cmd.load      = 1'b0;
    cmd.step      = 1'b0;
    unique case (state_r)
      ST_INIT: begin
        cmd.init_root = 1'b1;
        state_nxt     = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) begin
          cmd.load      = 1'b1;
          cmd.init_root = (action == ACT_CLEAR);
          if (walk_req) begin
            state_nxt = ST_WALK;
          end else begin
            strobe_nxt = 1'b1;
          end
        end
      end
      ST_WALK: begin
        cmd.step = 1'b1;
        if (sts.finish) begin
          strobe_nxt = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_INIT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_INIT;
      strobe_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      strobe_r <= strobe_nxt;
    end
  end

endmodule

// ===== sv/ipm_datapath.sv =====
`timescale 1ns / 1ps

module ipm_datapath (
  input  logic                clk,
  input  logic                rst_n,
  input  ipm_pkg::ipm_in_t    in_req,
  input  ipm_pkg::ipm_cmd_t   cmd,
  output ipm_pkg::ipm_sts_t   sts,
  output ipm_pkg::ipm_out_t   out_res
);
  import ipm_pkg::*;

  node_t                   node_mem [NODE_COUNT];
  node_t                   rd_data_r;
  idx_t                    rd_addr;
  logic                    wr_en;
  idx_t                    wr_addr;
  node_t                   wr_data;

  logic [ADDRESS_BITS-1:0] addr_r, addr_nxt;
  logic [LVL_W-1:0]        plen_r, plen_nxt;
  logic                    insert_r, insert_nxt;
  logic [LVL_W-1:0]        level_r, level_nxt;
  idx_t                    cur_r, cur_nxt;
  node_t                   entry_r, entry_nxt;
  logic                    use_reg_r, use_reg_nxt;
  logic [CNT_W-1:0]        used_r, used_nxt;
  ipm_out_t                res_r, res_nxt;

  node_t                   entry;
  node_t                   upd;
  logic [BIT_W-1:0]        bit_idx;
  logic                    addr_bit;
  idx_t                    child;
  logic                    missing;
  logic                    pool_full;
  idx_t                    new_idx;

  assign entry     = use_reg_r ? entry_r : rd_data_r;
  assign bit_idx   = BIT_W'(ADDRESS_BITS - 1) - level_r[BIT_W-1:0];
  assign addr_bit  = addr_r[bit_idx];
  assign child     = entry.child[addr_bit];
  assign missing   = (child == '0) || (CNT_W'(child) >= CNT_W'(NODE_COUNT));
  assign pool_full = (used_r >= CNT_W'(NODE_COUNT));
  assign new_idx   = used_r[IDX_W-1:0];
  assign out_res   = res_r;

  always_comb begin
    rd_addr     = cur_r;
    wr_en       = 1'b0;
    wr_addr     = cur_r;
    wr_data     = entry;
    upd         = entry;
    addr_nxt    = addr_r;
    plen_nxt    = plen_r;
    insert_nxt  = insert_r;
    level_nxt   = level_r;
    cur_nxt     = cur_r;
    entry_nxt   = entry_r;
    use_reg_nxt = use_reg_r;
    used_nxt    = used_r;
    res_nxt     = res_r;
    sts.finish  = 1'b0;

    if (cmd.init_root) begin
      wr_en    = 1'b1;
      wr_addr  = '0;
      wr_data  = '0;
      used_nxt = CNT_W'(1);
    end

    if (cmd.load) begin
      addr_nxt    = in_req.address;
      plen_nxt    = (in_req.prefix_length > PLEN_W'(ADDRESS_BITS)) ?
                    LVL_W'(ADDRESS_BITS) : LVL_W'(in_req.prefix_length);
      insert_nxt  = (in_req.action == ACT_INSERT);
      rd_addr     = '0;
      cur_nxt     = '0;
      level_nxt   = '0;
      use_reg_nxt = 1'b0;
      res_nxt     = '0;
    end

    if (cmd.step) begin
      if (insert_r) begin
        if (level_r == plen_r) begin
          upd.terminal = 1'b1;
          wr_en        = 1'b1;
          wr_data      = upd;
          sts.finish   = 1'b1;
          res_nxt      = '0;
        end else if (!missing) begin
          rd_addr     = child;
          cur_nxt     = child;
          use_reg_nxt = 1'b0;
          level_nxt   = level_r + LVL_W'(1);
        end else if (pool_full) begin
          // A freshly allocated node is written back here so that it is left cleared.
          wr_en          = 1'b1;
          wr_data        = entry;
          sts.finish     = 1'b1;
          res_nxt.status = 1'b1;
        end else begin
          upd.child[addr_bit] = new_idx;
          wr_en       = 1'b1;
          wr_data     = upd;
          cur_nxt     = new_idx;
          entry_nxt   = '0;
          use_reg_nxt = 1'b1;
          used_nxt    = used_r + CNT_W'(1);
          level_nxt   = level_r + LVL_W'(1);
        end
      end else begin
        if (entry.terminal) begin
          sts.finish      = 1'b1;
          res_nxt.matched = 1'b1;
        end else if ((level_r == LVL_W'(ADDRESS_BITS)) || missing) begin
          sts.finish = 1'b1;
          res_nxt    = '0;
        end else begin
          rd_addr   = child;
          cur_nxt   = child;
          level_nxt = level_r + LVL_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      node_mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= node_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r    <= CNT_W'(1);
      use_reg_r <= 1'b0;
      level_r   <= '0;
    end else begin
      used_r    <= used_nxt;
      use_reg_r <= use_reg_nxt;
      level_r   <= level_nxt;
    end
  end

  always_ff @(posedge clk) begin
    addr_r   <= addr_nxt;
    plen_r   <= plen_nxt;
    insert_r <= insert_nxt;
    cur_r    <= cur_nxt;
    entry_r  <= entry_nxt;
    res_r    <= res_nxt;
  end

endmodule

// ===== sv/ipv4_prefix_trie_match.sv =====
`timescale 1ns / 1ps

// Binary trie of IPv4 prefixes with insert, match and clear requests. A request is taken
// when start is high and busy is low; its single result appears on out_res, flagged by
// out_strobe for exactly one cycle, and must be taken then because the receiver cannot
// stall the block. Clear and the unused action code give their result in the cycle after
// the request. A match reads the root node and then walks down the trie one level at a
// time, over up to 32 levels, before it gives its result; an insert walks down to its
// prefix length unless the node pool runs full, and the match walk reads the node memory
// once per level. After reset busy stays high for one cycle while the root node is written.
module ipv4_prefix_trie_match (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  ipm_pkg::ipm_in_t  in_req,
  output logic              out_strobe,
  output ipm_pkg::ipm_out_t out_res
);
  import ipm_pkg::*;

  ipm_cmd_t cmd;
  ipm_sts_t sts;

  ipm_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .action     (in_req.action),
    .sts        (sts),
    .cmd        (cmd),
    .busy       (busy),
    .out_strobe (out_strobe)
  );

  ipm_datapath u_datapath (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (in_req),
    .cmd     (cmd),
    .sts     (sts),
    .out_res (out_res)
  );

endmodule

// ===== sv/ipm_checker.sv =====
`timescale 1ns / 1ps

module ipm_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              start,
  input logic              busy,
  input ipm_pkg::ipm_in_t  in_req,
  input logic              out_strobe,
  input ipm_pkg::ipm_out_t out_res
);
  import ipm_pkg::*;

  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_strobe)
    else $error("Result strobe seen straight after reset.");

  a_reset_busy: assert property (@(posedge clk) !rst_n |=> busy)
    else $error("Block not busy while the root is written after reset.");

  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> !busy)
    else $error("Result delivered while the block is still busy.");

  a_one_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> !(out_res.matched && out_res.status))
    else $error("Result reports both a match and a full pool.");

  a_clear_result: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_req.action == ACT_CLEAR))
    |=> (out_strobe && !out_res.matched && !out_res.status))
    else $error("Clear request did not give an empty result in the next cycle.");

endmodule

bind ipv4_prefix_trie_match ipm_checker u_ipm_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .start      (start),
  .busy       (busy),
  .in_req     (in_req),
  .out_strobe (out_strobe),
  .out_res    (out_res)
);

// ===== sim/ipm_result_checker.sv =====
`timescale 1ns / 1ps

module ipm_result_checker (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic              busy,
  input  ipm_pkg::ipm_in_t  in_req,
  input  logic              out_strobe,
  input  ipm_pkg::ipm_out_t out_res,
  output int                mismatches,
  output int                outstanding
);
  import ipm_pkg::*;

  node_t            shadow_nodes [NODE_COUNT];
  logic [CNT_W-1:0] shadow_used;
  ipm_out_t         predicted_results [$];
  ipm_out_t         want;
  ipm_out_t         got;
  int               fail_tally = 0;

  initial begin
    mismatches  = 0;
    outstanding = 0;
  end

  function automatic logic shadow_insert(logic [ADDRESS_BITS-1:0] addr,
                                         logic [PLEN_W-1:0] plen_raw);
    idx_t cur;
    idx_t nxt;
    int   plen;
    int   lvl;
    logic b;
    cur  = '0;
    plen = (plen_raw > ADDRESS_BITS) ? ADDRESS_BITS : int'(plen_raw);
    for (lvl = 0; lvl < plen; lvl++) begin
      b   = addr[ADDRESS_BITS-1-lvl];
      nxt = shadow_nodes[cur].child[b];
      if (nxt == '0) begin
        if (shadow_used >= NODE_COUNT) begin
          return 1'b1;
        end
        nxt = shadow_used[IDX_W-1:0];
        shadow_used = shadow_used + CNT_W'(1);
        shadow_nodes[nxt] = '0;
        shadow_nodes[cur].child[b] = nxt;
      end
      cur = nxt;
    end
    shadow_nodes[cur].terminal = 1'b1;
    return 1'b0;
  endfunction

  function automatic logic shadow_lookup(logic [ADDRESS_BITS-1:0] addr);
    idx_t cur;
    idx_t nxt;
    int   lvl;
    cur = '0;
    for (lvl = 0; lvl < ADDRESS_BITS; lvl++) begin
      if (shadow_nodes[cur].terminal) begin
        return 1'b1;
      end
      nxt = shadow_nodes[cur].child[addr[ADDRESS_BITS-1-lvl]];
      if (nxt == '0) begin
        return 1'b0;
      end
      cur = nxt;
    end
    return shadow_nodes[cur].terminal;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      shadow_nodes[0] = '0;
      shadow_used = CNT_W'(1);
      predicted_results.delete();
    end else begin
      // A result leaving at this edge always belongs to an earlier request.
      if (out_strobe === 1'b1) begin
        got = out_res;
        if (predicted_results.size() == 0) begin
          fail_tally++;
          $display("%0t: result with no request outstanding, got matched %0b status %0b",
                   $time, got.matched, got.status);
        end else begin
          want = predicted_results.pop_front();
          if (got.matched !== want.matched) begin
            fail_tally++;
            $display("%0t: matched mismatch, expected %0b got %0b",
                     $time, want.matched, got.matched);
          end
          if (got.status !== want.status) begin
            fail_tally++;
            $display("%0t: status mismatch, expected %0b got %0b",
                     $time, want.status, got.status);
          end
        end
      end
      if (start === 1'b1 && busy === 1'b0) begin
        want = '0;
        case (in_req.action)
          ACT_INSERT: begin
            want.status = shadow_insert(in_req.address, in_req.prefix_length);
          end
          ACT_MATCH: begin
            want.matched = shadow_lookup(in_req.address);
          end
          ACT_CLEAR: begin
            shadow_nodes[0] = '0;
            shadow_used = CNT_W'(1);
          end
          default: begin
          end
        endcase
        predicted_results = {predicted_results, want};
      end
    end
    mismatches  <= fail_tally;
    outstanding <= predicted_results.size();
  end

endmodule

// ===== sim/tb_ipv4_prefix_trie_match.sv =====
`timescale 1ns / 1ps

module tb_ipv4_prefix_trie_match;
  import ipm_pkg::*;

  localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;
  localparam int QUIET_LIMIT = 1000;
  localparam int MAX_GAP     = 40;

  logic     clk;
  logic     rst_n;
  logic     start;
  logic     busy;
  ipm_in_t  in_req;
  logic     out_strobe;
  ipm_out_t out_res;
  int       mismatches;
  int       outstanding;
  int       idle_pct;
  int       quiet_cycles;

  logic [ADDRESS_BITS-1:0] prefix_base [$];
  int                      prefix_len  [$];

  ipv4_prefix_trie_match dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_req     (in_req),
    .out_strobe (out_strobe),
    .out_res    (out_res)
  );

  ipm_result_checker trie_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .in_req      (in_req),
    .out_strobe  (out_strobe),
    .out_res     (out_res),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    quiet_cycles = 0;
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_strobe) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Returns at the edge where the request is taken, with start still high.
  task automatic issue(logic [ACT_W-1:0] act, logic [ADDRESS_BITS-1:0] addr,
                       logic [PLEN_W-1:0] plen);
    int gap;
    gap = 0;
    while (gap < MAX_GAP && $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
      gap++;
    end
    start <= 1'b1;
    in_req <= '{action: act, address: addr, prefix_length: plen};
    do @(posedge clk); while (busy);
  endtask

  task automatic note_prefix(logic [ADDRESS_BITS-1:0] addr, logic [PLEN_W-1:0] plen);
    prefix_base = {prefix_base, addr};
    prefix_len  = {prefix_len, ((plen > ADDRESS_BITS) ? ADDRESS_BITS : int'(plen))};
  endtask

  task automatic issue_clear();
    issue(ACT_CLEAR, $urandom(), PLEN_W'($urandom_range(63)));
    prefix_base.delete();
    prefix_len.delete();
  endtask

  // Addresses mostly near a stored prefix, so that lookups walk deep into the trie.
  task automatic issue_lookup();
    int                      pick;
    int                      len;
    logic [ADDRESS_BITS-1:0] keep;
    logic [ADDRESS_BITS-1:0] addr;
    addr = $urandom();
    if (prefix_base.size() > 0 && $urandom_range(9) < 7) begin
      pick = $urandom_range(prefix_base.size() - 1);
      len  = prefix_len[pick];
      keep = (len == 0) ? '0 : (32'hFFFF_FFFF << (ADDRESS_BITS - len));
      addr = (prefix_base[pick] & keep) | (addr & ~keep);
      if (len > 0 && $urandom_range(2) == 0) begin
        addr = addr ^ (32'h1 << (ADDRESS_BITS - $urandom_range(1, len)));
      end
    end
    issue(ACT_MATCH, addr, PLEN_W'($urandom_range(63)));
  endtask

  task automatic random_item();
    int                      roll;
    int                      shape;
    logic [ADDRESS_BITS-1:0] addr;
    logic [PLEN_W-1:0]       plen;
    roll  = $urandom_range(999);
    shape = $urandom_range(99);
    addr  = $urandom();
    if (shape < 1) begin
      plen = '0;
    end else if (shape < 6) begin
      plen = PLEN_W'($urandom_range(33, 63));
    end else begin
      plen = PLEN_W'($urandom_range(1, 32));
    end
    if (roll < 30) begin
      issue_clear();
    end else if (roll < 40) begin
      issue(ACT_UNUSED, addr, PLEN_W'($urandom_range(63)));
    end else if (roll < 340) begin
      issue(ACT_INSERT, addr, plen);
      note_prefix(addr, plen);
    end else begin
      issue_lookup();
    end
  endtask

  initial begin
    int phase_idle [4];
    int n;
    int pick;
    logic [ADDRESS_BITS-1:0] addr;

    phase_idle = '{0, 57, 0, 23};
    idle_pct = 0;
    rst_n  <= 1'b0;
    start  <= 1'b0;
    in_req <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    issue(ACT_MATCH,  32'h0000_0000, 6'd0);
    issue(ACT_MATCH,  32'hFFFF_FFFF, 6'd63);
    issue(ACT_INSERT, 32'h0A00_0000, 6'd8);
    issue(ACT_MATCH,  32'h0A01_0203, 6'd0);
    issue(ACT_MATCH,  32'h0B00_0000, 6'd0);
    issue(ACT_INSERT, 32'hFFFF_FFFF, 6'd32);
    issue(ACT_MATCH,  32'hFFFF_FFFF, 6'd0);
    issue(ACT_MATCH,  32'hFFFF_FFFE, 6'd0);
    issue(ACT_INSERT, 32'hFFFF_FFFF, 6'd32);
    issue(ACT_INSERT, 32'h0000_0000, 6'd63);
    issue(ACT_MATCH,  32'h0000_0000, 6'd0);
    issue(ACT_MATCH,  32'h0000_0001, 6'd0);
    issue(ACT_INSERT, 32'h8000_0001, 6'd33);
    issue(ACT_MATCH,  32'h8000_0001, 6'd63);
    issue(ACT_UNUSED, 32'hFFFF_FFFF, 6'd63);
    issue(ACT_MATCH,  32'h0A7F_FFFF, 6'd63);
    issue(ACT_CLEAR,  32'hFFFF_FFFF, 6'd63);
    issue(ACT_MATCH,  32'h0A01_0203, 6'd0);
    issue(ACT_INSERT, 32'h1234_5678, 6'd0);
    issue(ACT_MATCH,  32'h1234_5678, 6'd0);
    issue(ACT_MATCH,  32'hEDCB_A987, 6'd0);
    issue(ACT_CLEAR,  32'h0000_0000, 6'd0);
    issue(ACT_INSERT, 32'hC0A8_0000, 6'd16);
    issue(ACT_MATCH,  32'hC0A8_FFFF, 6'd0);
    issue(ACT_CLEAR,  32'h0000_0000, 6'd0);

    for (int p = 0; p < 4; p++) begin
      idle_pct = phase_idle[p];
      repeat (80) random_item();
    end

    // Fill the node pool with host routes until inserts report it full.
    idle_pct = 23;
    issue_clear();
    for (n = 0; n < 200; n++) begin
      addr = $urandom();
      issue(ACT_INSERT, addr, 6'd32);
      note_prefix(addr, 6'd32);
      if (n % 4 == 3) begin
        issue_lookup();
      end
    end
    repeat (30) begin
      if ($urandom_range(1) == 0) begin
        pick = $urandom_range(prefix_base.size() - 1);
        issue(ACT_INSERT, prefix_base[pick], PLEN_W'($urandom_range(0, 32)));
      end else begin
        issue(ACT_INSERT, $urandom(), PLEN_W'($urandom_range(1, 63)));
      end
    end
    repeat (30) issue_lookup();
    issue_clear();
    repeat (10) random_item();

    start <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/ipm_pkg.sv
sv/ipm_ctrl.sv
sv/ipm_datapath.sv
sv/ipv4_prefix_trie_match.sv
sv/ipm_checker.sv
sim/ipm_result_checker.sv
sim/tb_ipv4_prefix_trie_match.sv
